[src/sscr_pkg.sv]
`timescale 1ns / 1ps

package sscr_pkg;

    localparam int unsigned MEM_BYTES = 6912;
    localparam int unsigned ATTR_BASE = 6144;
    localparam int unsigned ADDR_W    = 13;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [7:0] LVL_NORMAL = 8'd192;
    localparam logic [7:0] LVL_BRIGHT = 8'd255;
    localparam logic [7:0] LVL_TINT   = 8'd96;

    typedef struct packed {
        logic                operation;
        logic [ADDR_W-1:0]   address;
        logic [7:0]          write_data;
        logic [7:0]          row;
        logic [4:0]          column;
        logic                flash_phase;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic mem_write;
        logic load_item;
        logic rd_bitmap;
        logic rd_attr;
        logic cap_bits;
        logic cap_attr;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last_px;
    } t_dp_stat;

    // idx[0] blue, idx[1] red, idx[2] green, idx[3] bright
    function automatic logic [7:0] pal_level(input logic tinted, input logic [3:0] idx,
                                             input logic on);
        logic [7:0] lvl;
        begin
            lvl = 8'd0;
            if (on) begin
                lvl = idx[3] ? LVL_BRIGHT : LVL_NORMAL;
            end else if (tinted && idx[3] && (idx[2:0] != 3'd0)) begin
                lvl = LVL_TINT;
            end
            return lvl;
        end
    endfunction

    function automatic t_rgb pal_lookup(input logic tinted, input logic [3:0] idx);
        t_rgb c;
        begin
            c.red   = pal_level(tinted, idx, idx[1]);
            c.green = pal_level(tinted, idx, idx[2]);
            c.blue  = pal_level(tinted, idx, idx[0]);
            return c;
        end
    endfunction

endpackage

[src/sscr_ctrl.sv]
`timescale 1ns / 1ps

module sscr_ctrl import sscr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_operation,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_BM = 3'd1;
    localparam logic [2:0] S_RD_AT = 3'd2;
    localparam logic [2:0] S_LD_AT = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign w_take      = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.mem_write = w_take && (i_operation == OP_WRITE);
        o_cmd.load_item = w_take && (i_operation == OP_RENDER);
        o_cmd.rd_bitmap = (r_state == S_RD_BM);
        o_cmd.rd_attr   = (r_state == S_RD_AT);
        o_cmd.cap_bits  = (r_state == S_RD_AT);
        o_cmd.cap_attr  = (r_state == S_LD_AT);
        o_cmd.advance   = o_out_valid && i_out_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load_item) n_state = S_RD_BM;
            end
            S_RD_BM: n_state = S_RD_AT;
            S_RD_AT: n_state = S_LD_AT;
            S_LD_AT: n_state = S_EMIT;
            S_EMIT: begin
                if (o_cmd.advance && i_stat.last_px) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/sscr_datapath.sv]
`timescale 1ns / 1ps

module sscr_datapath import sscr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_item
);

    logic [7:0]        r_mem [0:MEM_BYTES-1];
    logic [7:0]        r_rd_data;
    logic              r_rd_zero;
    logic              r_pal_sel;
    logic [7:0]        r_row;
    logic [4:0]        r_col;
    logic              r_fphase;
    logic [7:0]        r_bits;
    logic [7:0]        r_attr;
    logic [2:0]        r_px;

    logic [ADDR_W-1:0] w_bm_addr;
    logic [ADDR_W-1:0] w_at_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_byte;
    logic              w_bit;
    logic [3:0]        w_idx;
    t_rgb              w_rgb;

    // interleaved layout: third, line within char, char row, column
    assign w_bm_addr = {r_row[7:6], r_row[2:0], r_row[5:3], r_col};
    assign w_at_addr = ADDR_W'(ATTR_BASE) + {3'b000, r_row[7:3], r_col};
    assign w_rd_addr = i_cmd.rd_attr ? w_at_addr : w_bm_addr;
    assign w_rd_byte = r_rd_zero ? 8'd0 : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && (i_item.address < ADDR_W'(MEM_BYTES))) begin
            r_mem[i_item.address] <= i_item.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_bitmap || i_cmd.rd_attr) begin
            r_rd_zero <= (w_rd_addr >= ADDR_W'(MEM_BYTES));
            if (w_rd_addr < ADDR_W'(MEM_BYTES)) begin
                r_rd_data <= r_mem[w_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_sel <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_pal_sel <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_row    <= i_item.row;
            r_col    <= i_item.column;
            r_fphase <= i_item.flash_phase;
        end
        if (i_cmd.cap_bits) begin
            r_bits <= w_rd_byte;
        end
        if (i_cmd.cap_attr) begin
            r_attr <= w_rd_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= 3'd0;
        end else if (i_cmd.cap_attr) begin
            r_px <= 3'd0;
        end else if (i_cmd.advance) begin
            r_px <= r_px + 3'd1;
        end
    end

    assign w_bit = r_bits[~r_px] ^ (r_fphase & r_attr[7]);
    assign w_idx = {r_attr[6], w_bit ? r_attr[2:0] : r_attr[5:3]};
    assign w_rgb = pal_lookup(r_pal_sel, w_idx);

    assign o_stat.last_px = (r_px == 3'd7);

    always_comb begin
        o_item.red     = w_rgb.red;
        o_item.green   = w_rgb.green;
        o_item.blue    = w_rgb.blue;
        o_item.pixel_x = {r_col, r_px};
        o_item.pixel_y = r_row;
        o_item.last    = o_stat.last_px;
    end

endmodule

[src/spectrum_screen_cell_render.sv]
`timescale 1ns / 1ps

// Screen cell renderer holding the 6912-byte screen memory (bitmap then
// attributes). A write item stores one byte and gives nothing back. A render
// item is latched on accept; states S_RD_BM, S_RD_AT and S_LD_AT then fetch the
// bitmap byte and the attribute through the single memory read port. Eight
// pixel items then stream out, leftmost first, one per cycle while the sink is
// ready. No new item is taken until the eighth pixel leaves. Reading a byte
// never written gives undefined colour.
module spectrum_screen_cell_render import sscr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sscr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    sscr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_item        (o_out_item)
    );

    a_busy_when_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while pixels pending");

    a_last_ends_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.last) |=> !o_out_valid)
        else $error("pixel after last of cell");

    a_last_matches_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.pixel_x[2:0] == 3'd7) == o_out_item.last))
        else $error("last flag out of step with pixel position");

    a_render_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && (i_in_item.operation == OP_RENDER))
            |=> ##3 o_out_valid)
        else $error("render did not reach pixel output in time");

endmodule

[test/spectrum_cell_checker.sv]
`timescale 1ns / 1ps

module spectrum_cell_checker import sscr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    output int        o_errors,
    output int        o_pending
);

    logic [7:0] screen [MEM_BYTES];
    logic       tinted = 1'b1;
    t_out_item  pending_pixels [$];
    t_out_item  want;
    int         err_cnt = 0;

    function automatic t_rgb shade(input logic tint, input logic [3:0] idx);
        logic [23:0] c;
        begin
            case (idx)
                4'd0:    c = 24'h000000;
                4'd1:    c = 24'h0000C0;
                4'd2:    c = 24'hC00000;
                4'd3:    c = 24'hC000C0;
                4'd4:    c = 24'h00C000;
                4'd5:    c = 24'h00C0C0;
                4'd6:    c = 24'hC0C000;
                4'd7:    c = 24'hC0C0C0;
                4'd8:    c = 24'h000000;
                4'd9:    c = tint ? 24'h6060FF : 24'h0000FF;
                4'd10:   c = tint ? 24'hFF6060 : 24'hFF0000;
                4'd11:   c = tint ? 24'hFF60FF : 24'hFF00FF;
                4'd12:   c = tint ? 24'h60FF60 : 24'h00FF00;
                4'd13:   c = tint ? 24'h60FFFF : 24'h00FFFF;
                4'd14:   c = tint ? 24'hFFFF60 : 24'hFFFF00;
                default: c = 24'hFFFFFF;
            endcase
            return c;
        end
    endfunction

    // beyond the end of memory reads as zero
    function automatic logic [7:0] peek(input int unsigned a);
        return (a < MEM_BYTES) ? screen[a] : 8'h00;
    endfunction

    task automatic predict_cell_pixels(input t_in_item it);
        int unsigned cell_pos;
        int unsigned bm;
        int unsigned at;
        logic [7:0]  bits;
        logic [7:0]  attr;
        logic [3:0]  idx;
        t_rgb        c;
        t_out_item   px;
        begin
            cell_pos = it.row * 32 + it.column;
            bm = (cell_pos & 32'h1F)
               | (((cell_pos >> 8) & 32'h7) << 5)
               | (((cell_pos >> 5) & 32'h7) << 8)
               | (((cell_pos >> 11) & 32'h3) << 11);
            at = ATTR_BASE + (it.row >> 3) * 32 + it.column;
            bits = peek(bm);
            attr = peek(at);
            for (int k = 0; k < 8; k++) begin
                idx[3]   = attr[6];
                idx[2:0] = (bits[7-k] ^ (it.flash_phase & attr[7])) ? attr[2:0] : attr[5:3];
                c = shade(tinted, idx);
                px.red     = c.red;
                px.green   = c.green;
                px.blue    = c.blue;
                px.pixel_x = 8'(it.column * 8 + k);
                px.pixel_y = it.row;
                px.last    = (k == 7);
                pending_pixels.push_back(px);
            end
        end
    endtask

    task automatic field_check(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            err_cnt++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tinted = 1'b1;
            pending_pixels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                tinted = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.operation == OP_WRITE) begin
                    if (i_in_item.address < MEM_BYTES) begin
                        screen[i_in_item.address] = i_in_item.write_data;
                    end
                end else begin
                    predict_cell_pixels(i_in_item);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    err_cnt++;
                    $display("%0t: pixel expected none, got %h", $time, i_out_item);
                end else begin
                    want = pending_pixels.pop_front();
                    field_check("red", want.red, i_out_item.red);
                    field_check("green", want.green, i_out_item.green);
                    field_check("blue", want.blue, i_out_item.blue);
                    field_check("pixel_x", want.pixel_x, i_out_item.pixel_x);
                    field_check("pixel_y", want.pixel_y, i_out_item.pixel_y);
                    field_check("last", {7'd0, want.last}, {7'd0, i_out_item.last});
                end
            end
        end
        o_pending <= pending_pixels.size();
        o_errors  <= err_cnt;
    end

endmodule

[test/tb_spectrum_screen_cell_render.sv]
`timescale 1ns / 1ps

module tb_spectrum_screen_cell_render import sscr_pkg::*; ();

    localparam int SETTLE    = 16;
    localparam int LONG_HOLD = 400;
    localparam int CHUNK     = 92;

    typedef enum int {RX_FREE, RX_HALF, RX_MOSTLY, RX_PATTERN} t_rx_mode;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      in_valid    = 1'b0;
    logic      in_ready;
    t_in_item  in_item     = '0;
    logic      out_valid;
    logic      out_ready   = 1'b0;
    t_out_item out_item;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    int        errors;
    int        pending;
    int        hold_tag    = 0;
    int        burst_left  = 0;
    bit        written [MEM_BYTES];

    spectrum_screen_cell_render u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    spectrum_cell_checker u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] rnd_byte();
        if ($urandom_range(0, 7) == 0) begin
            return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom);
    endfunction

    function automatic t_in_item wr_item(input int unsigned addr, input logic [7:0] data);
        t_in_item it;
        begin
            it = $bits(t_in_item)'({$urandom, $urandom});
            it.operation  = OP_WRITE;
            it.address    = ADDR_W'(addr);
            it.write_data = data;
            return it;
        end
    endfunction

    function automatic t_in_item rd_item(input logic [7:0] row, input logic [4:0] col,
                                         input logic phase);
        t_in_item it;
        begin
            it = $bits(t_in_item)'({$urandom, $urandom});
            it.operation   = OP_RENDER;
            it.row         = row;
            it.column      = col;
            it.flash_phase = phase;
            return it;
        end
    endfunction

    function automatic int unsigned bitmap_offset(input logic [7:0] row, input logic [4:0] col);
        return 32'({row[7:6], row[2:0], row[5:3], col});
    endfunction

    function automatic int unsigned attr_offset(input logic [7:0] row, input logic [4:0] col);
        return ATTR_BASE + row[7:3] * 32 + col;
    endfunction

    function automatic bit readable(input int unsigned a);
        return (a >= MEM_BYTES) || written[a];
    endfunction

    task automatic push(input t_in_item it);
        int gap;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            in_valid <= 1'b1;
            in_item  <= it;
            do @(posedge clk); while (!in_ready);
            burst_left--;
            if (it.operation == OP_WRITE && it.address < MEM_BYTES) begin
                written[it.address] = 1'b1;
            end
        end
    endtask

    // wait for every pixel, then let a trailing write settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_palette(input logic sel);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_run(input int n);
        int          done_cnt;
        int          pick;
        logic [7:0]  row;
        logic [4:0]  col;
        int unsigned ba;
        int unsigned aa;
        begin
            done_cnt = 0;
            while (done_cnt < n) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0) begin
                    row = 8'($urandom_range(192, 255));
                end else begin
                    row = 8'($urandom_range(0, 191));
                end
                col = 5'($urandom);
                ba  = bitmap_offset(row, col);
                aa  = attr_offset(row, col);
                if (pick < 60) begin
                    // fill the cell, then draw it
                    if (ba < MEM_BYTES && (!written[ba] || $urandom_range(0, 1) == 1)) begin
                        push(wr_item(ba, rnd_byte()));
                        done_cnt++;
                    end
                    if (aa < MEM_BYTES && (!written[aa] || $urandom_range(0, 1) == 1)) begin
                        push(wr_item(aa, rnd_byte()));
                        done_cnt++;
                    end
                    push(rd_item(row, col, 1'($urandom)));
                    done_cnt++;
                end else if (pick < 80 && readable(ba) && readable(aa)) begin
                    push(rd_item(row, col, 1'($urandom)));
                    done_cnt++;
                end else if (pick < 94) begin
                    push(wr_item($urandom_range(0, MEM_BYTES - 1), rnd_byte()));
                    done_cnt++;
                end else begin
                    // out of range, dropped by the block
                    push(wr_item($urandom_range(MEM_BYTES, 8191), rnd_byte()));
                end
            end
        end
    endtask

    initial begin : receiver
        t_rx_mode   mode;
        int         span;
        int         held;
        int         seen_tag;
        logic [7:0] pat;
        mode     = RX_FREE;
        span     = 0;
        held     = 0;
        seen_tag = 0;
        pat      = 8'hFF;
        forever begin
            @(posedge clk);
            if (hold_tag != seen_tag) begin
                seen_tag = hold_tag;
                held     = LONG_HOLD;
            end
            if (held > 0) begin
                held--;
                out_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    span = $urandom_range(40, 300);
                    pat  = 8'($urandom);
                end
                span--;
                case (mode)
                    RX_FREE: begin
                        out_ready <= 1'b1;
                    end
                    RX_HALF: begin
                        out_ready <= ($urandom_range(0, 1) == 1);
                    end
                    RX_MOSTLY: begin
                        out_ready <= ($urandom_range(0, 4) != 0);
                    end
                    default: begin
                        pat = {pat[6:0], pat[7]};
                        out_ready <= pat[0];
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_palette(1'b1);

        // corner cells: first and last cell, rows past the screen, flash, bright paper
        push(wr_item(0, 8'hA5));
        push(wr_item(ATTR_BASE, 8'b1100_1010));
        push(rd_item(8'd0, 5'd0, 1'b0));
        push(rd_item(8'd0, 5'd0, 1'b1));
        push(wr_item(6143, 8'hFF));
        push(wr_item(MEM_BYTES - 1, 8'h38));
        push(rd_item(8'd191, 5'd31, 1'b1));
        push(wr_item(MEM_BYTES, 8'h00));
        push(wr_item(8191, 8'hFF));
        push(rd_item(8'd192, 5'd0, 1'b1));
        push(rd_item(8'd255, 5'd31, 1'b0));
        push(wr_item(6405, 8'h5B));
        push(rd_item(8'd193, 5'd5, 1'b0));
        push(wr_item(35, 8'h0F));
        push(wr_item(6179, 8'b0100_1000));
        push(rd_item(8'd8, 5'd3, 1'b1));
        drain();

        set_palette(1'b0);
        random_run(CHUNK);
        drain();

        set_palette(1'b1);
        hold_tag <= hold_tag + 1;
        random_run(CHUNK);
        drain();

        set_palette(1'b0);
        random_run(CHUNK);
        drain();

        set_palette(1'b1);
        random_run(CHUNK);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[spectrum_screen_cell_render.f]
src/sscr_pkg.sv
src/sscr_ctrl.sv
src/sscr_datapath.sv
src/spectrum_screen_cell_render.sv
test/spectrum_cell_checker.sv
test/tb_spectrum_screen_cell_render.sv
